FILE: rtl/core/ascl_pkg.sv
// ----------------------------------------------------------------------------
// ascl_pkg
// Shared constants, types and helper functions for the assembly source line
// cleaner: character codes, the output load select and the control and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package ascl_pkg;

   // Depth of the pending whitespace store and the widths that follow from it.
   localparam int PENDING_DEPTH = 15;
   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_VT   = 8'h0B;
   localparam logic [7:0] CH_FF   = 8'h0C;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_SPC  = 8'h20;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_LC_A = 8'h61;
   localparam logic [7:0] CH_LC_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Source of the byte loaded into the output register.
   typedef enum logic [2:0] {
      OUT_NONE,
      OUT_DIRECT,
      OUT_BUF,
      OUT_HELD,
      OUT_END
   } out_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        take;
      out_sel_type out_sel;
      logic        out_last;
      logic        idx_clr;
      logic        idx_inc;
      logic        clr_count;
      logic        end_text;
   } ascl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic flush_needed;
      logic single_result;
      logic idx_at_last;
      logic held_last;
   } ascl_status_type;

   // Whitespace that does not end a line.
   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPC) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) ||
             (c == CH_CR);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[CH_LC_A:CH_LC_Z]}) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/ascl_ctrl.sv
// ----------------------------------------------------------------------------
// ascl_ctrl
// Controller state machine: takes input bytes, sequences the whitespace flush,
// the held character and the end marker into the output register.
// ----------------------------------------------------------------------------
module ascl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_end_of_input,
   output logic                     req_stall,
   input  ascl_pkg::ascl_status_type status,
   output ascl_pkg::ascl_cmd_type    cmd
);
   import ascl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_CHAR,
      ST_FINAL
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.out_sel   = OUT_NONE;
      req_stall     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !status.out_free;
            if (req_valid && status.out_free) begin
               cmd.take = 1'b1;
               if (status.flush_needed) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_FLUSH;
               end else if (status.single_result) begin
                  cmd.out_sel  = OUT_DIRECT;
                  cmd.out_last = !req_end_of_input;
                  if (req_end_of_input) begin
                     state_in = ST_FINAL;
                  end
               end else if (req_end_of_input) begin
                  cmd.out_sel  = OUT_END;
                  cmd.out_last = 1'b1;
                  cmd.end_text = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.out_sel = OUT_BUF;
               cmd.idx_inc = 1'b1;
               if (status.idx_at_last) begin
                  state_in = ST_CHAR;
               end
            end
         end
         ST_CHAR: begin
            if (status.out_free) begin
               cmd.out_sel   = OUT_HELD;
               cmd.out_last  = !status.held_last;
               cmd.clr_count = 1'b1;
               state_in      = status.held_last ? ST_FINAL : ST_IDLE;
            end
         end
         ST_FINAL: begin
            if (status.out_free) begin
               cmd.out_sel  = OUT_END;
               cmd.out_last = 1'b1;
               cmd.end_text = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/ascl_dp.sv
// ----------------------------------------------------------------------------
// ascl_dp
// Datapath: byte classification, line state, pending whitespace store and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module ascl_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [7:0]                req_in_char,
   input  logic                      req_end_of_input,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_out_char,
   output logic                      rsp_last_of_run,
   output logic                      rsp_end_marker,
   output logic                      rsp_text_nonempty,
   output logic                      rsp_space_overflow,
   input  ascl_pkg::ascl_cmd_type    cmd,
   output ascl_pkg::ascl_status_type status
);
   import ascl_pkg::*;

   logic             in_comment_ff, in_comment_in;
   logic             line_ff, line_in;
   logic             emitted_ff, emitted_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       held_ff;
   logic             held_last_ff;
   logic [7:0]       space_mem_ff [PENDING_DEPTH];

   logic             rsp_valid_ff;
   logic [7:0]       out_char_ff;
   logic             out_last_ff, out_end_ff, out_nonempty_ff, out_ovf_ff;

   logic is_eol, is_semi, is_sp, comment_now, kept, space_keep, emit_nl, mem_wr;
   logic count_full, out_free;

   // Classification of the byte on the input channel.
   always_comb begin
      is_eol      = (req_in_char == CH_LF) || (req_in_char == CH_NUL);
      is_semi     = (req_in_char == CH_SEMI);
      is_sp       = is_blank(req_in_char);
      comment_now = in_comment_ff || is_semi;
      kept        = !is_eol && !comment_now && !is_sp;
      space_keep  = !is_eol && !comment_now && is_sp && line_ff;
      emit_nl     = (req_in_char == CH_LF) && line_ff;
      count_full  = (count_ff == CNT_W'(PENDING_DEPTH));
      mem_wr      = cmd.take && space_keep && !count_full;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status.out_free      = out_free;
      status.flush_needed  = kept && (count_ff != '0);
      status.single_result = (kept && (count_ff == '0)) || emit_nl;
      status.idx_at_last   = (CNT_W'(idx_ff) == count_ff - CNT_W'(1));
      status.held_last     = held_last_ff;
   end

   // Line state update: the input transaction first, then the end of text.
   always_comb begin
      in_comment_in = in_comment_ff;
      line_in       = line_ff;
      emitted_in    = emitted_ff;
      ovf_in        = ovf_ff;
      count_in      = count_ff;
      if (cmd.take) begin
         if (is_eol) begin
            in_comment_in = 1'b0;
            line_in       = 1'b0;
            count_in      = '0;
            if (emit_nl) begin
               emitted_in = 1'b1;
            end
         end else begin
            if (is_semi) begin
               in_comment_in = 1'b1;
            end
            if (kept) begin
               line_in    = 1'b1;
               emitted_in = 1'b1;
            end
            if (space_keep) begin
               if (count_full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
      end
      if (cmd.clr_count) begin
         count_in = '0;
      end
      if (cmd.end_text) begin
         in_comment_in = 1'b0;
         line_in       = 1'b0;
         count_in      = '0;
         emitted_in    = 1'b0;
      end
   end

   // Flush index.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_comment_ff <= 1'b0;
         line_ff       <= 1'b0;
         emitted_ff    <= 1'b0;
         ovf_ff        <= 1'b0;
         count_ff      <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_comment_ff <= in_comment_in;
         line_ff       <= line_in;
         emitted_ff    <= emitted_in;
         ovf_ff        <= ovf_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         if (cmd.out_sel != OUT_NONE) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Pending whitespace store and the held character.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         space_mem_ff[count_ff[IDX_W-1:0]] <= req_in_char;
      end
      if (cmd.take) begin
         held_ff      <= to_upper(req_in_char);
         held_last_ff <= req_end_of_input;
      end
   end

   // Output register of the result channel.
   always_ff @(posedge clock) begin
      if (cmd.out_sel != OUT_NONE) begin
         out_last_ff     <= cmd.out_last;
         out_ovf_ff      <= ovf_in;
         out_end_ff      <= 1'b0;
         out_nonempty_ff <= 1'b0;
         case (cmd.out_sel)
            OUT_DIRECT: out_char_ff <= emit_nl ? CH_LF : to_upper(req_in_char);
            OUT_BUF:    out_char_ff <= space_mem_ff[idx_ff];
            OUT_HELD:   out_char_ff <= held_ff;
            OUT_END: begin
               out_char_ff     <= CH_NUL;
               out_end_ff      <= 1'b1;
               out_nonempty_ff <= emitted_ff;
            end
            default:    out_char_ff <= CH_NUL;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_char       = out_char_ff;
   assign rsp_last_of_run    = out_last_ff;
   assign rsp_end_marker     = out_end_ff;
   assign rsp_text_nonempty  = out_nonempty_ff;
   assign rsp_space_overflow = out_ovf_ff;

endmodule

FILE: rtl/core/asm_source_line_cleaner_core.sv
// ----------------------------------------------------------------------------
// asm_source_line_cleaner_core
// Cleans assembly source text one byte at a time: strips comments, leading and
// trailing whitespace and empty lines, and folds letters to upper case.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  req      in         req_valid/req_stall req_in_char, req_end_of_input
//  rsp      out        rsp_valid/rsp_stall rsp_out_char, rsp_last_of_run,
//                                          rsp_end_marker, rsp_text_nonempty,
//                                          rsp_space_overflow
//
//  A byte with at most one result goes straight to the output register; a new
//  byte is accepted every cycle while the controller is idle and the output
//  register drains. A kept byte after n pending whitespace bytes follows the
//  n stored bytes from the single read port; end of input adds the end marker.
//  Synchronous active-high reset clears all line state and the output valid.
//  rsp_stall holds the output register; req_stall rises while it is full and
//  stalled and while a flush, a held character or an end marker is sequenced.
// ----------------------------------------------------------------------------
module asm_source_line_cleaner_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_of_run,
   output logic       rsp_end_marker,
   output logic       rsp_text_nonempty,
   output logic       rsp_space_overflow
);
   import ascl_pkg::*;

   ascl_cmd_type    cmd;
   ascl_status_type status;

   // Sequencer.
   ascl_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_end_of_input (req_end_of_input),
      .req_stall        (req_stall),
      .status           (status),
      .cmd              (cmd)
   );

   // Line state, whitespace store and output register.
   ascl_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_in_char        (req_in_char),
      .req_end_of_input   (req_end_of_input),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_end_marker     (rsp_end_marker),
      .rsp_text_nonempty  (rsp_text_nonempty),
      .rsp_space_overflow (rsp_space_overflow),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

FILE: rtl/core/ascl_checker.sv
// ----------------------------------------------------------------------------
// ascl_checker
// Port-level checks on the result channel of the source line cleaner.
// ----------------------------------------------------------------------------
module ascl_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last_of_run,
   input logic       rsp_end_marker,
   input logic       rsp_text_nonempty,
   input logic       rsp_space_overflow
);
   import ascl_pkg::*;

   // The end marker closes the run of its byte and carries a NUL.
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_marker) |-> (rsp_last_of_run && (rsp_out_char == CH_NUL)))
      else $error("end marker without last_of_run or with nonzero byte");

   // text_nonempty is reported only on the end marker.
   a_nonempty_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_end_marker) |-> !rsp_text_nonempty)
      else $error("text_nonempty set on an ordinary result");

   // The overflow flag is sticky across results.
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_space_overflow) |=> (!rsp_valid || rsp_space_overflow))
      else $error("space_overflow dropped after being reported");

   // A stalled result transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_char) &&
                                    $stable(rsp_last_of_run)))
      else $error("stalled result changed");

endmodule

bind asm_source_line_cleaner_core ascl_checker u_ascl_checker (.*);
